// ===== src/lcb_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and address helpers for the LED cube refresh block.
// No dependencies.
package lcb_pkg;

  localparam int SIZE_X      = 8;
  localparam int SIZE_Y      = 8;
  localparam int SIZE_Z      = 8;
  localparam int MAX_DEPTH   = 8;

  localparam int LAYER_BYTES = (SIZE_X * SIZE_Y + 7) / 8;
  localparam int CUBE_BYTES  = LAYER_BYTES * SIZE_Z;
  localparam int SEL_BYTES   = (SIZE_Z + 7) / 8;
  localparam int CHAN_BYTES  = MAX_DEPTH * CUBE_BYTES;
  localparam int BANK_BYTES  = 3 * CHAN_BYTES;
  localparam int STORE_DEPTH = 2 * BANK_BYTES;

  localparam int ADDR_W  = $clog2(STORE_DEPTH);
  localparam int LAYER_W = (SIZE_Z > 1) ? $clog2(SIZE_Z) : 1;
  localparam int PLANE_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int BYTE_W  = (LAYER_BYTES > 1) ? $clog2(LAYER_BYTES) : 1;
  localparam int SEL_W   = (SEL_BYTES > 1) ? $clog2(SEL_BYTES) : 1;

  typedef enum logic [1:0] {
    ACT_WRITE   = 2'd0,
    ACT_TICK    = 2'd1,
    ACT_PRESENT = 2'd2,
    ACT_COPY    = 2'd3
  } action_t;

  localparam logic [1:0] REG_COLOR_MODE = 2'd0;
  localparam logic [1:0] REG_BIT_DEPTH  = 2'd1;
  localparam logic [1:0] REG_AUTO_CLEAR = 2'd2;

  typedef enum logic [3:0] {
    S_CLR_ALL,
    S_IDLE,
    S_FIN,
    S_WR_RD,
    S_WR_MOD,
    S_TICK,
    S_CLR,
    S_COPY,
    S_COPY_END
  } state_t;

  typedef struct packed {
    logic [LAYER_W-1:0] layer;
    logic [PLANE_W-1:0] plane;
    logic               frame_wrap;
  } mod_pos_t;

  function automatic logic [3:0] eff_depth(input logic [3:0] bd);
    logic [3:0] d;
    d = bd;
    if (d == 4'd0) d = 4'd1;
    if (d > 4'(MAX_DEPTH)) d = 4'(MAX_DEPTH);
    return d;
  endfunction

  function automatic logic [7:0] clamp_level(input logic [7:0] level, input logic [3:0] d);
    logic [7:0] maxb;
    maxb = 8'hFF >> (4'd8 - d);
    return (level > maxb) ? maxb : level;
  endfunction

  function automatic logic [ADDR_W-1:0] plane_base(input logic bank, input logic [1:0] ch,
                                                   input logic [PLANE_W-1:0] plane);
    return ADDR_W'(bank) * ADDR_W'(BANK_BYTES) + ADDR_W'(ch) * ADDR_W'(CHAN_BYTES)
         + ADDR_W'(plane) * ADDR_W'(CUBE_BYTES);
  endfunction

  function automatic logic [ADDR_W-1:0] layer_off(input logic [LAYER_W-1:0] layer,
                                                  input logic [BYTE_W-1:0] idx);
    return ADDR_W'(layer) * ADDR_W'(LAYER_BYTES) + ADDR_W'(idx);
  endfunction

endpackage

// ===== src/lcb_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request items and shifted result bytes.
// Depends on nothing.
interface lcb_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [6:0] layer_z;
  logic [6:0] row_x;
  logic [6:0] col_y;
  logic [7:0] red_level;
  logic [7:0] green_level;
  logic [7:0] blue_level;
  logic [2:0] channel_mask;
  logic       wait_frame_end;
  modport source(output valid, action, layer_z, row_x, col_y, red_level, green_level,
                 blue_level, channel_mask, wait_frame_end, input ready);
  modport sink(input valid, action, layer_z, row_x, col_y, red_level, green_level,
               blue_level, channel_mask, wait_frame_end, output ready);
endinterface

interface lcb_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] shift_byte;
  logic       latch_now;
  modport source(output valid, shift_byte, latch_now, input ready);
  modport sink(input valid, shift_byte, latch_now, output ready);
endinterface

// ===== src/lcb_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

// ===== src/lcb_mod_ctr.sv =====
`timescale 1ns / 1ps
// Bit angle modulation counters: weight, plane and layer, advanced once per tick.
// Depends on lcb_pkg.
module lcb_mod_ctr import lcb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [3:0] depth,
  output mod_pos_t   pos
);
  logic [7:0]         weight;
  logic [PLANE_W-1:0] plane;
  logic [LAYER_W-1:0] layer;
  logic [8:0]         weight_inc;
  logic [3:0]         plane_inc;
  logic [4:0]         layer_inc;
  logic               wrap_w;
  logic               wrap_p;
  logic               wrap_l;

  always_comb begin
    weight_inc = 9'(weight) + 9'd1;
    plane_inc  = 4'(plane) + 4'd1;
    layer_inc  = 5'(layer) + 5'd1;
    wrap_w     = weight_inc >= (9'd1 << plane);
    wrap_p     = plane_inc >= depth;
    wrap_l     = layer_inc >= 5'(SIZE_Z);
    pos.layer  = layer;
    pos.plane  = plane;
    pos.frame_wrap = wrap_w && wrap_p && wrap_l;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      weight <= '0;
      plane  <= '0;
      layer  <= '0;
    end else if (advance) begin
      if (!wrap_w) begin
        weight <= weight_inc[7:0];
      end else begin
        weight <= '0;
        if (!wrap_p) begin
          plane <= plane_inc[PLANE_W-1:0];
        end else begin
          plane <= '0;
          layer <= wrap_l ? '0 : layer_inc[LAYER_W-1:0];
        end
      end
    end
  end
endmodule

// ===== src/led_cube_bam_refresh.sv =====
`timescale 1ns / 1ps
// LED cube bit angle modulation refresh engine, top level.
// Depends on lcb_pkg, lcb_if, lcb_ram and lcb_mod_ctr.
//
// Usage: request items enter on a valid/ready channel; one item is worked at a
// time and ready stays low until it is finished. A write voxel item does a
// read-modify-write of one store byte per selected channel and plane, each as
// a read state followed by a modify state. A refresh tick streams 25 bytes in
// RGB mode (9 in single colour) to the result channel, one byte per cycle from
// the store read port while the receiver takes them, then advances the
// modulation counters. A present with swap and auto clear, or a tick that
// swaps at frame end with auto clear, sweeps the back bank (1536 bytes) at one
// byte per cycle. A copy reads the front bank and writes it to the back bank.
// Present without clear passes through S_FIN back to idle. Throughput is set
// by the single store write port and read port. After reset the whole store
// (3072 bytes) is cleared before the first item is accepted; configuration
// writes are taken at any time. A stalled receiver holds the result beat in
// the output register and the byte stream pauses behind it.
module led_cube_bam_refresh import lcb_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  lcb_req_if.sink     request,
  lcb_res_if.source   result,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [3:0]  cfg_data
);
  state_t state, state_next;

  logic       color_mode;
  logic [3:0] bit_depth;
  logic       auto_clear;
  logic       front_bank;
  logic       swap_pending;

  logic [ADDR_W-1:0] cnt;
  logic [ADDR_W-1:0] cp_waddr;
  logic              cp_pend;

  logic [1:0]         wr_ch;
  logic [PLANE_W-1:0] wr_plane;
  logic [ADDR_W-1:0]  wr_off;
  logic [2:0]         wr_bit;
  logic [2:0]         wr_mask;
  logic [7:0]         lvl [3];

  logic [1:0]        tk_ch;
  logic [BYTE_W-1:0] tk_k;
  logic [SEL_W-1:0]  tk_j;
  logic              tk_sel;
  logic              tk_issued;
  logic              rd_pend;
  logic              s1_sel;
  logic [7:0]        s1_byte;
  logic              s1_last;

  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_latch;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  logic [3:0] depth;
  mod_pos_t   mpos;
  logic       advance;
  logic       accept;
  logic       take;
  logic       issue;
  logic       in_range;
  logic [7:0] pos;
  logic [9:0] sum;
  logic [7:0] avg;
  logic [7:0] layer8;
  logic [7:0] sel_val;
  logic       do_swap;

  assign depth        = eff_depth(bit_depth);
  assign request.ready = (state == S_IDLE);
  assign accept       = request.valid && request.ready;
  assign result.valid = out_valid;
  assign result.shift_byte = out_byte;
  assign result.latch_now  = out_latch;

  lcb_ram #(.WIDTH(8), .DEPTH(STORE_DEPTH)) u_store (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .re(ram_re), .raddr(ram_raddr), .rdata(ram_rdata)
  );

  lcb_mod_ctr u_ctr (
    .clk(clk), .rst(rst), .advance(advance), .depth(depth), .pos(mpos)
  );

  always_comb begin
    in_range = (request.layer_z < 7'(SIZE_Z)) && (request.row_x < 7'(SIZE_X))
            && (request.col_y < 7'(SIZE_Y));
    pos      = 8'(request.col_y) + 8'(request.row_x) * 8'(SIZE_Y);
    sum      = 10'(request.red_level) + 10'(request.green_level) + 10'(request.blue_level);
    avg      = 8'((20'(sum) * 20'd683) >> 11);
    layer8   = 8'(mpos.layer);
    sel_val  = (8'(tk_j) == (layer8 >> 3)) ? (8'd1 << layer8[2:0]) : 8'd0;
    take     = rd_pend && (!out_valid || result.ready);
    issue    = (state == S_TICK) && !tk_issued && (!rd_pend || take);
    advance  = (state == S_TICK) && tk_issued && !rd_pend;
    do_swap  = advance && mpos.frame_wrap && swap_pending;
  end

  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = '0;
    unique case (state)
      S_CLR_ALL: begin
        ram_we    = 1'b1;
        ram_waddr = cnt;
        if (cnt == ADDR_W'(STORE_DEPTH - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          unique case (action_t'(request.action))
            ACT_WRITE:   state_next = in_range ? S_WR_RD : S_FIN;
            ACT_TICK:    state_next = S_TICK;
            ACT_PRESENT: state_next = (!request.wait_frame_end && auto_clear) ? S_CLR : S_FIN;
            ACT_COPY:    state_next = S_COPY;
          endcase
        end
      end
      S_FIN: state_next = S_IDLE;
      S_WR_RD: begin
        if (wr_mask[wr_ch]) begin
          ram_re    = 1'b1;
          ram_raddr = plane_base(!front_bank, wr_ch, wr_plane) + wr_off;
          state_next = S_WR_MOD;
        end else if (wr_ch == 2'd2) begin
          state_next = S_IDLE;
        end
      end
      S_WR_MOD: begin
        ram_we    = 1'b1;
        ram_waddr = plane_base(!front_bank, wr_ch, wr_plane) + wr_off;
        ram_wdata = lvl[wr_ch][wr_plane] ? (ram_rdata | (8'd1 << wr_bit))
                                         : (ram_rdata & ~(8'd1 << wr_bit));
        if (wr_plane == PLANE_W'(depth - 4'd1) && wr_ch == 2'd2) begin
          state_next = S_IDLE;
        end else begin
          state_next = S_WR_RD;
        end
      end
      S_TICK: begin
        if (issue && !tk_sel) begin
          ram_re    = 1'b1;
          ram_raddr = plane_base(front_bank, tk_ch, mpos.plane) + layer_off(mpos.layer, tk_k);
        end
        if (advance) begin
          state_next = (do_swap && auto_clear) ? S_CLR : S_IDLE;
        end
      end
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = plane_base(!front_bank, 2'd0, '0) + cnt;
        if (cnt == ADDR_W'(BANK_BYTES - 1)) state_next = S_IDLE;
      end
      S_COPY: begin
        ram_re    = 1'b1;
        ram_raddr = plane_base(front_bank, 2'd0, '0) + cnt;
        ram_we    = cp_pend;
        ram_waddr = cp_waddr;
        ram_wdata = ram_rdata;
        if (cnt == ADDR_W'(BANK_BYTES - 1)) state_next = S_COPY_END;
      end
      S_COPY_END: begin
        ram_we    = 1'b1;
        ram_waddr = cp_waddr;
        ram_wdata = ram_rdata;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR_ALL;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode <= 1'b1;
      bit_depth  <= 4'd4;
      auto_clear <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_COLOR_MODE: color_mode <= cfg_data[0];
        REG_BIT_DEPTH:  bit_depth  <= cfg_data;
        REG_AUTO_CLEAR: auto_clear <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_bank   <= 1'b0;
      swap_pending <= 1'b0;
      cnt          <= '0;
      cp_pend      <= 1'b0;
      rd_pend      <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
        out_byte  <= s1_sel ? s1_byte : ram_rdata;
        out_latch <= s1_last;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (issue) begin
        rd_pend <= 1'b1;
      end else if (take) begin
        rd_pend <= 1'b0;
      end
      if (do_swap) begin
        front_bank   <= !front_bank;
        swap_pending <= 1'b0;
      end
      unique case (state)
        S_CLR_ALL, S_CLR: cnt <= cnt + 1'b1;
        S_IDLE: begin
          cnt     <= '0;
          cp_pend <= 1'b0;
          if (accept && action_t'(request.action) == ACT_PRESENT) begin
            if (request.wait_frame_end) begin
              swap_pending <= 1'b1;
            end else begin
              front_bank   <= !front_bank;
              swap_pending <= 1'b0;
            end
          end
        end
        S_COPY: begin
          cnt      <= cnt + 1'b1;
          cp_pend  <= 1'b1;
          cp_waddr <= plane_base(!front_bank, 2'd0, '0) + cnt;
        end
        S_TICK: cnt <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        wr_ch     <= 2'd0;
        wr_plane  <= '0;
        wr_off    <= layer_off(LAYER_W'(request.layer_z), BYTE_W'(pos >> 3));
        wr_bit    <= pos[2:0];
        tk_ch     <= color_mode ? 2'd2 : 2'd0;
        tk_k      <= BYTE_W'(LAYER_BYTES - 1);
        tk_j      <= SEL_W'(SEL_BYTES - 1);
        tk_sel    <= 1'b0;
        tk_issued <= 1'b0;
        if (color_mode) begin
          wr_mask <= request.channel_mask;
          lvl[0]  <= clamp_level(request.red_level, depth);
        end else begin
          wr_mask <= 3'b001;
          lvl[0]  <= clamp_level(avg, depth);
        end
        lvl[1] <= clamp_level(request.green_level, depth);
        lvl[2] <= clamp_level(request.blue_level, depth);
      end
      S_WR_RD: begin
        if (!wr_mask[wr_ch] && wr_ch != 2'd2) wr_ch <= wr_ch + 2'd1;
      end
      S_WR_MOD: begin
        if (wr_plane == PLANE_W'(depth - 4'd1)) begin
          wr_plane <= '0;
          if (wr_ch != 2'd2) wr_ch <= wr_ch + 2'd1;
        end else begin
          wr_plane <= wr_plane + 1'b1;
        end
      end
      S_TICK: begin
        if (issue) begin
          if (!tk_sel) begin
            s1_sel  <= 1'b0;
            s1_last <= 1'b0;
            if (tk_k == '0) begin
              tk_k <= BYTE_W'(LAYER_BYTES - 1);
              if (tk_ch == 2'd0) tk_sel <= 1'b1;
              else tk_ch <= tk_ch - 2'd1;
            end else begin
              tk_k <= tk_k - 1'b1;
            end
          end else begin
            s1_sel  <= 1'b1;
            s1_byte <= sel_val;
            s1_last <= (tk_j == '0);
            if (tk_j == '0) tk_issued <= 1'b1;
            else tk_j <= tk_j - 1'b1;
          end
        end
      end
      default: ;
    endcase
  end
endmodule

// ===== src/lcb_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the LED cube refresh block, bound to the top level.
// Depends on lcb_pkg.
module lcb_checker import lcb_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic [1:0] req_action,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] res_byte,
  input logic       res_latch
);
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_byte) && $stable(res_latch))
    else $error("result beat dropped or changed while stalled");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !req_ready && !res_valid)
    else $error("block not quiet after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("ready right after an accepted item");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && req_action != ACT_TICK && !res_valid |=> !res_valid)
    else $error("result beat from an item that makes none");
endmodule

bind led_cube_bam_refresh lcb_checker u_lcb_checker (
  .clk(clk), .rst(rst),
  .req_valid(request.valid), .req_ready(request.ready), .req_action(request.action),
  .res_valid(result.valid), .res_ready(result.ready),
  .res_byte(result.shift_byte), .res_latch(result.latch_now)
);
